// ===== rtl/u8u16_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// u8u16_pkg: shared types and constants of the UTF-8 to UTF-16 transcoder
// Holds the request and response transfer types, the code point constants
// and the small decode helpers used by the transcoder datapath.
// ----------------------------------------------------------------------------
package u8u16_pkg;

   localparam int unsigned BYTE_W    = 8;
   localparam int unsigned UNIT_W    = 16;
   localparam int unsigned CP_W      = 21;
   localparam int unsigned MAX_UNITS = 3;
   localparam int unsigned CNT_W     = $clog2(MAX_UNITS + 1);

   localparam logic [UNIT_W-1:0] REPLACEMENT_CHAR = 16'hFFFD;
   localparam logic [UNIT_W-1:0] SURR_HIGH_BASE   = 16'hD800;
   localparam logic [UNIT_W-1:0] SURR_LOW_BASE    = 16'hDC00;
   localparam logic [CP_W-1:0]   SUPP_PLANE_BASE  = 21'h10000;

   typedef struct packed {
      logic [BYTE_W-1:0] in_byte;
      logic              end_of_string;
   } req_type;

   typedef struct packed {
      logic [UNIT_W-1:0] code_unit;
      logic              last_of_item;
      logic              string_done;
   } rsp_type;

   // A byte decoded on its own: ASCII passes through, anything else is U+FFFD.
   function automatic logic [UNIT_W-1:0] single_unit(input logic [BYTE_W-1:0] b);
      logic [UNIT_W-1:0] u;
      if (b[7] == 1'b0) begin
         u = {{(UNIT_W-BYTE_W){1'b0}}, b};
      end else begin
         u = REPLACEMENT_CHAR;
      end
      return u;
   endfunction

   // Number of continuation bytes announced by a lead byte.
   function automatic logic [1:0] lead_extra(input logic [BYTE_W-1:0] b);
      logic [1:0] e;
      priority if (b[7:5] == 3'b110) begin
         e = 2'd1;
      end else if (b[7:4] == 4'b1110) begin
         e = 2'd2;
      end else if (b[7:3] == 5'b11110) begin
         e = 2'd3;
      end else begin
         e = 2'd0;
      end
      return e;
   endfunction

   // Payload bits that a lead byte contributes to the code point.
   function automatic logic [CP_W-1:0] lead_bits(input logic [BYTE_W-1:0] b);
      logic [CP_W-1:0] c;
      priority if (b[7:5] == 3'b110) begin
         c = {16'd0, b[4:0]};
      end else if (b[7:4] == 4'b1110) begin
         c = {17'd0, b[3:0]};
      end else begin
         c = {18'd0, b[2:0]};
      end
      return c;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/utf8_to_utf16be_transcoder_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// utf8_to_utf16be_transcoder_top: UTF-8 byte stream to UTF-16 code units
// Decodes one UTF-8 byte per transfer and delivers UTF-16 code units, one per
// transfer, to be serialized high byte first.
// ----------------------------------------------------------------------------

// The transcoder takes one UTF-8 byte per cycle on the request channel,
// unless req_stall holds it, and delivers UTF-16 code units, one per cycle
// unless rsp_stall holds them, on the response channel. A byte is registered
// on arrival, decoded in the following cycle against the open sequence
// state, and its units (none, one, two or three) are loaded as a group into
// the response register, from which the first unit of the byte is offered.
// A byte that completes no unit passes through the input register without
// touching the response side. A byte that yields k units holds the response
// register until all k have been taken, one per unit transfer, and longer
// while the receiver stalls; meanwhile a following byte with units stalls
// the request side. The next byte with units is decoded in the cycle its
// predecessor's last unit is taken, so a stream of ASCII bytes runs at one
// byte per cycle while the receiver does not stall. Lead bytes are
// classified by their top bits, continuation bytes are taken unchecked
// (only their low six bits count), and invalid leads or stray continuation
// bytes give U+FFFD. Code points from 0x10000 upward leave as a surrogate
// pair. When end_of_string arrives inside a sequence, the lead gives U+FFFD
// and the bytes buffered after it are decoded again as leads. The last unit
// caused by a byte carries last_of_item, and on the final byte of a string
// it also carries string_done; the decoder then returns to its idle state.

module utf8_to_utf16be_transcoder_top (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output      logic                 req_stall,
   input  wire u8u16_pkg::req_type   req_data,
   output      logic                 rsp_valid,
   input  wire logic                 rsp_stall,
   output      u8u16_pkg::rsp_type   rsp_data
);

   // Input register.
   logic                             in_valid_ff, in_valid_in;
   u8u16_pkg::req_type               in_ff;

   // Decoder state: continuation bytes still due, bytes buffered, the code
   // point being assembled and the first continuation byte (only it is ever
   // decoded again on an early end of string).
   logic [1:0]                       need_ff, need_in;
   logic [1:0]                       pcnt_ff, pcnt_in;
   logic [u8u16_pkg::CP_W-1:0]       acc_ff, acc_in;
   logic [u8u16_pkg::BYTE_W-1:0]     mid_ff, mid_in;

   // Response group register: the units of one byte, drained one at a time.
   logic                             grp_valid_ff, grp_valid_in;
   logic [u8u16_pkg::UNIT_W-1:0]     grp_unit_ff [u8u16_pkg::MAX_UNITS];
   logic [u8u16_pkg::CNT_W-1:0]      grp_cnt_ff;
   logic [1:0]                       grp_idx_ff, grp_idx_in;
   logic                             grp_eos_ff;

   // Decode results for the byte in the input register.
   logic [u8u16_pkg::UNIT_W-1:0]     dec_unit [u8u16_pkg::MAX_UNITS];
   logic [u8u16_pkg::CNT_W-1:0]      dec_cnt;
   logic [u8u16_pkg::CP_W-1:0]       acc_shift;
   logic [u8u16_pkg::CP_W-1:0]       supp_off;
   logic [1:0]                       extra;
   logic [1:0]                       need_dec;
   logic [u8u16_pkg::BYTE_W-1:0]     b;

   logic                             fire;
   logic                             out_xfer;
   logic                             grp_last;
   logic                             grp_free;

   // -------------------------------------------------------------------------
   // Handshake control. A decoded byte leaves the input register when it
   // produces no unit, or when the group register is empty or hands over its
   // last unit in this cycle.
   // -------------------------------------------------------------------------
   assign out_xfer  = grp_valid_ff && !rsp_stall;
   assign grp_last  = (grp_idx_ff == (grp_cnt_ff - 2'd1));
   assign grp_free  = !grp_valid_ff || (out_xfer && grp_last);
   assign fire      = in_valid_ff && ((dec_cnt == '0) || grp_free);
   assign req_stall = in_valid_ff && !fire;

   assign rsp_valid              = grp_valid_ff;
   assign rsp_data.code_unit     = grp_unit_ff[grp_idx_ff];
   assign rsp_data.last_of_item  = grp_last;
   assign rsp_data.string_done   = grp_last && grp_eos_ff;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (!req_stall) begin
         in_valid_in = req_valid;
      end
   end

   // -------------------------------------------------------------------------
   // Decoder. All paths are a few byte-wide compares, one 21-bit subtract for
   // the surrogate offset and one 16-bit add for the high surrogate.
   // -------------------------------------------------------------------------
   assign b         = in_ff.in_byte;
   assign extra     = u8u16_pkg::lead_extra(b);
   assign acc_shift = {acc_ff[u8u16_pkg::CP_W-7:0], b[5:0]};
   assign supp_off  = acc_shift - u8u16_pkg::SUPP_PLANE_BASE;
   assign need_dec  = need_ff - 2'd1;

   always_comb begin
      dec_unit[0] = u8u16_pkg::REPLACEMENT_CHAR;
      dec_unit[1] = u8u16_pkg::REPLACEMENT_CHAR;
      dec_unit[2] = u8u16_pkg::REPLACEMENT_CHAR;
      dec_cnt     = '0;
      need_in     = need_ff;
      pcnt_in     = pcnt_ff;
      acc_in      = acc_ff;
      mid_in      = mid_ff;

      if (need_ff == 2'd0) begin
         // Looking at a lead byte.
         if (extra == 2'd0) begin
            dec_unit[0] = u8u16_pkg::single_unit(b);
            dec_cnt     = 2'd1;
         end else if (in_ff.end_of_string) begin
            dec_cnt     = 2'd1;
         end else begin
            need_in = extra;
            pcnt_in = 2'd1;
            acc_in  = u8u16_pkg::lead_bits(b);
         end
      end else begin
         // Continuation slot: the byte is taken whatever it is.
         acc_in  = acc_shift;
         need_in = need_dec;
         if (need_dec == 2'd0) begin
            pcnt_in = 2'd0;
            acc_in  = '0;
            if (acc_shift >= u8u16_pkg::SUPP_PLANE_BASE) begin
               dec_unit[0] = u8u16_pkg::SURR_HIGH_BASE
                           + {5'd0, supp_off[u8u16_pkg::CP_W-1:10]};
               dec_unit[1] = u8u16_pkg::SURR_LOW_BASE | {6'd0, supp_off[9:0]};
               dec_cnt     = 2'd2;
            end else begin
               dec_unit[0] = acc_shift[u8u16_pkg::UNIT_W-1:0];
               dec_cnt     = 2'd1;
            end
         end else if (in_ff.end_of_string) begin
            // Early end: the lead becomes U+FFFD, the rest is decoded as leads.
            if (pcnt_ff == 2'd1) begin
               dec_unit[1] = u8u16_pkg::single_unit(b);
               dec_cnt     = 2'd2;
            end else if (mid_ff[7:5] == 3'b110) begin
               dec_unit[1] = {5'd0, mid_ff[4:0], b[5:0]};
               dec_cnt     = 2'd2;
            end else begin
               dec_unit[1] = u8u16_pkg::single_unit(mid_ff);
               dec_unit[2] = u8u16_pkg::single_unit(b);
               dec_cnt     = 2'd3;
            end
         end else begin
            if (pcnt_ff == 2'd1) begin
               mid_in = b;
            end
            if (pcnt_ff != 2'd3) begin
               pcnt_in = pcnt_ff + 2'd1;
            end
         end
      end

      if (in_ff.end_of_string) begin
         need_in = 2'd0;
         pcnt_in = 2'd0;
         acc_in  = '0;
      end
   end

   // -------------------------------------------------------------------------
   // Response group sequencing.
   // -------------------------------------------------------------------------
   always_comb begin
      grp_valid_in = grp_valid_ff;
      grp_idx_in   = grp_idx_ff;
      if (fire && (dec_cnt != '0)) begin
         grp_valid_in = 1'b1;
         grp_idx_in   = 2'd0;
      end else if (out_xfer) begin
         if (grp_last) begin
            grp_valid_in = 1'b0;
         end else begin
            grp_idx_in = grp_idx_ff + 2'd1;
         end
      end
   end

   // -------------------------------------------------------------------------
   // Registers.
   // -------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         need_ff      <= 2'd0;
         pcnt_ff      <= 2'd0;
         acc_ff       <= '0;
         grp_valid_ff <= 1'b0;
         grp_idx_ff   <= 2'd0;
      end else begin
         in_valid_ff  <= in_valid_in;
         grp_valid_ff <= grp_valid_in;
         grp_idx_ff   <= grp_idx_in;
         if (fire) begin
            need_ff <= need_in;
            pcnt_ff <= pcnt_in;
            acc_ff  <= acc_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         in_ff <= req_data;
      end
      if (fire) begin
         mid_ff <= mid_in;
      end
      if (fire && (dec_cnt != '0)) begin
         grp_unit_ff[0] <= dec_unit[0];
         grp_unit_ff[1] <= dec_unit[1];
         grp_unit_ff[2] <= dec_unit[2];
         grp_cnt_ff     <= dec_cnt;
         grp_eos_ff     <= in_ff.end_of_string;
      end
   end

`ifndef SYNTHESIS
   // The drain index always points inside the loaded group.
   a_idx_in_group: assert property (@(posedge clock) disable iff (reset)
      grp_valid_ff |-> (grp_cnt_ff != '0) && (grp_idx_ff < grp_cnt_ff))
      else $error("response index outside its unit group");

   // An open sequence always has its lead buffered.
   a_open_has_lead: assert property (@(posedge clock) disable iff (reset)
      (need_ff != 2'd0) |-> (pcnt_ff != 2'd0))
      else $error("continuation due with no buffered lead");

   // The final byte of a string leaves the decoder idle.
   a_eos_idle: assert property (@(posedge clock) disable iff (reset)
      (fire && in_ff.end_of_string) |=> (need_ff == 2'd0) && (pcnt_ff == 2'd0))
      else $error("decoder not idle after end of string");

   // Every end-of-string byte produces at least one unit.
   a_eos_has_unit: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && in_ff.end_of_string) |-> (dec_cnt != '0))
      else $error("end of string byte produced no unit");

   // A byte that yields no unit never disturbs a group waiting on the output.
   a_silent_keeps_group: assert property (@(posedge clock) disable iff (reset)
      (fire && (dec_cnt == '0) && grp_valid_ff && !out_xfer)
      |=> grp_valid_ff && $stable(grp_idx_ff))
      else $error("silent byte disturbed a pending response");
`endif

endmodule
`default_nettype wire

// ===== verif/tb_utf8_to_utf16be_transcoder_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_utf8_to_utf16be_transcoder_top: self-checking bench for the transcoder
// Sends UTF-8 strings one byte per transfer, predicts the UTF-16 units that
// each byte must produce, and checks every response transfer in order.
// ----------------------------------------------------------------------------
module tb_utf8_to_utf16be_transcoder_top;

   // Run bounds. The cycle limit sits far above the slowest legal run: about
   // 430 bytes, up to three units each, every unit held by long receiver stalls.
   localparam int LIMIT_CYCLES  = 200000;
   localparam int DRAIN_CYCLES  = 20;
   localparam int RANDOM_BYTES  = 400;
   localparam int REPORT_LIMIT  = 10;

   // Code point constants, kept local so that the prediction does not lean on
   // the design's own package values.
   localparam logic [15:0] UNIT_REPLACEMENT = 16'hFFFD;
   localparam logic [15:0] HIGH_SURROGATE   = 16'hD800;
   localparam logic [15:0] LOW_SURROGATE    = 16'hDC00;
   localparam logic [20:0] PLANE1_START     = 21'h10000;
   localparam int          UNITS_PER_BYTE   = 3;

   // -------------------------------------------------------------------------
   // Scoreboard: mirrors the decoder state, turns every accepted byte into the
   // units it must cause, and compares response transfers against them.
   // -------------------------------------------------------------------------
   class u8u16_scoreboard;
      u8u16_pkg::rsp_type expected_units[$];
      logic [15:0] byte_units[$];
      logic [7:0]  held_bytes [3];
      logic [1:0]  held_count;
      logic [1:0]  owed_count;
      logic [20:0] partial_cp;
      int          mismatches;
      int          units_seen;
      int          bytes_seen;
      int          strings_seen;

      function new();
         held_bytes   = '{default: 8'h00};
         held_count   = 2'd0;
         owed_count   = 2'd0;
         partial_cp   = 21'd0;
         mismatches   = 0;
         units_seen   = 0;
         bytes_seen   = 0;
         strings_seen = 0;
      endfunction

      // Returns the number of continuation bytes a lead announces and the
      // payload bits it carries. Anything that cannot lead gives U+FFFD.
      function int lead_class(input logic [7:0] b, output logic [20:0] seed);
         if (b[7] == 1'b0) begin
            seed = {13'd0, b};
            return 0;
         end
         if (b[7:5] == 3'b110) begin
            seed = {16'd0, b[4:0]};
            return 1;
         end
         if (b[7:4] == 4'b1110) begin
            seed = {17'd0, b[3:0]};
            return 2;
         end
         if (b[7:3] == 5'b11110) begin
            seed = {18'd0, b[2:0]};
            return 3;
         end
         seed = {5'd0, UNIT_REPLACEMENT};
         return 0;
      endfunction

      function void push_unit(input logic [15:0] u);
         if (byte_units.size() < UNITS_PER_BYTE) begin
            byte_units = {byte_units, u};
         end
      endfunction

      // Supplementary code points leave as a pair; the high unit is cut to
      // 16 bits, which also covers values beyond the Unicode range.
      function void push_code(input logic [20:0] cp);
         logic [20:0] offset;
         if (cp >= PLANE1_START) begin
            offset = cp - PLANE1_START;
            push_unit(HIGH_SURROGATE + {5'd0, offset[20:10]});
            push_unit(LOW_SURROGATE + {6'd0, offset[9:0]});
         end else begin
            push_unit(cp[15:0]);
         end
      endfunction

      // Redecodes the buffered bytes of a string that ended inside a sequence.
      // A sequence that does not fit gives U+FFFD and decoding resumes at the
      // byte after its lead.
      function void decode_tail(input logic [7:0] tail[4], input int len);
         int          i;
         int          k;
         int          extra;
         logic [20:0] cp;
         i = 0;
         while (i < len) begin
            extra = lead_class(tail[i], cp);
            if (extra > 0 && i + extra < len) begin
               for (k = 1; k <= extra; k++) begin
                  cp = {cp[14:0], tail[i + k][5:0]};
               end
               i += extra;
            end else if (extra > 0) begin
               cp = {5'd0, UNIT_REPLACEMENT};
            end
            i++;
            push_code(cp);
         end
      endfunction

      // Called for every accepted request transfer.
      function void note_byte(input u8u16_pkg::req_type item);
         logic [7:0]  b;
         logic        eos;
         int          extra;
         int          k;
         logic [20:0] cp;
         logic [7:0]  tail [4];
         u8u16_pkg::rsp_type unit;
         b   = item.in_byte;
         eos = item.end_of_string;
         bytes_seen++;
         byte_units.delete();
         if (owed_count == 2'd0) begin
            extra = lead_class(b, cp);
            if (extra == 0) begin
               push_code(cp);
            end else if (eos) begin
               push_code({5'd0, UNIT_REPLACEMENT});
            end else begin
               held_bytes[0] = b;
               held_count    = 2'd1;
               owed_count    = extra[1:0];
               partial_cp    = cp;
            end
         end else begin
            // Continuation slots take any byte; only its low six bits count.
            partial_cp = {partial_cp[14:0], b[5:0]};
            owed_count = owed_count - 2'd1;
            if (owed_count == 2'd0) begin
               push_code(partial_cp);
               held_count = 2'd0;
               partial_cp = 21'd0;
            end else if (eos) begin
               for (k = 0; k < held_count; k++) begin
                  tail[k] = held_bytes[k];
               end
               tail[held_count] = b;
               decode_tail(tail, held_count + 1);
            end else if (held_count < 2'd3) begin
               held_bytes[held_count] = b;
               held_count++;
            end
         end
         if (eos) begin
            held_count = 2'd0;
            owed_count = 2'd0;
            partial_cp = 21'd0;
            strings_seen++;
         end
         foreach (byte_units[n]) begin
            unit.code_unit    = byte_units[n];
            unit.last_of_item = (n == byte_units.size() - 1);
            unit.string_done  = eos && (n == byte_units.size() - 1);
            expected_units    = {expected_units, unit};
         end
      endfunction

      function void log_mismatch(input string what, input u8u16_pkg::rsp_type want,
                                 input u8u16_pkg::rsp_type got);
         mismatches++;
         if (mismatches <= REPORT_LIMIT) begin
            $display("%0t: %s at unit %0d: expected unit %04h last %0b done %0b,",
                     $time, what, units_seen, want.code_unit, want.last_of_item,
                     want.string_done);
            $display("      got unit %04h last %0b done %0b",
                     got.code_unit, got.last_of_item, got.string_done);
         end
      endfunction

      // Called for every accepted response transfer.
      function void check_unit(input u8u16_pkg::rsp_type got);
         u8u16_pkg::rsp_type want;
         units_seen++;
         if (expected_units.size() == 0) begin
            log_mismatch("unit with nothing expected", '0, got);
            return;
         end
         want = expected_units.pop_front();
         if (got.code_unit !== want.code_unit ||
             got.last_of_item !== want.last_of_item ||
             got.string_done !== want.string_done) begin
            log_mismatch("unit mismatch", want, got);
         end
      endfunction

      function int outstanding();
         return expected_units.size();
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Signals. Every input of the block holds a known value from time zero.
   // -------------------------------------------------------------------------
   logic               clock     = 1'b0;
   logic               reset     = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   u8u16_pkg::req_type req_data  = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   u8u16_pkg::rsp_type rsp_data;

   // Idle mix of the current phase, in percent of cycles.
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int cycle_count    = 0;

   u8u16_scoreboard units_board;

   utf8_to_utf16be_transcoder_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   // The receiver decides at each falling edge whether to hold off the next
   // response transfer. This runs independently of rsp_valid, so stalls land
   // on every phase of the unit delivery, including while a byte's units are
   // still being handed out one by one.
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);
   end

   // Both channels are observed at the rising edge, where the design's own
   // registers have not yet moved. A request transfer is noted before the
   // response at the same edge is checked, which keeps the order right even
   // if a byte's unit were ever to appear in the same cycle.
   always @(posedge clock) begin
      cycle_count++;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            units_board.note_byte(req_data);
         end
         if (rsp_valid && !rsp_stall) begin
            units_board.check_unit(rsp_data);
         end
      end
   end

   // Watchdog: a hung handshake or a lost unit ends the run here.
   initial begin
      while (cycle_count < LIMIT_CYCLES) @(posedge clock);
      $display("timeout after %0d cycles, %0d units still expected",
               cycle_count, units_board.outstanding());
      $display("[FAIL] regression broken");
      $finish;
   end

   // -------------------------------------------------------------------------
   // Request side. Each call starts at a falling edge, may idle first, then
   // holds the byte until its transfer and returns at the next falling edge.
   // Valid is only ever written once per falling edge.
   // -------------------------------------------------------------------------
   task automatic send_byte(input logic [7:0] b, input logic eos);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid              <= 1'b1;
      req_data.in_byte       <= b;
      req_data.end_of_string <= eos;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   // Builds one well-formed UTF-8 character with random content. Four-byte
   // leads run up to 0xF7, so code points past U+10FFFF show up as well.
   function automatic int make_char(output logic [7:0] seq[4]);
      int len;
      int k;
      len = $urandom_range(1, 4);
      case (len)
         1: seq[0] = 8'($urandom_range(8'h00, 8'h7F));
         2: seq[0] = 8'($urandom_range(8'hC0, 8'hDF));
         3: seq[0] = 8'($urandom_range(8'hE0, 8'hEF));
         default: seq[0] = 8'($urandom_range(8'hF0, 8'hF7));
      endcase
      for (k = 1; k < len; k++) begin
         seq[k] = 8'($urandom_range(8'h80, 8'hBF));
      end
      return len;
   endfunction

   // One random string of one to eight characters. Most characters are well
   // formed; some are raw noise bytes, and some strings are cut off in the
   // middle of their last character so that the end-of-string flush runs
   // against one, two or three buffered bytes.
   task automatic send_random_string(inout int sent);
      logic [7:0] text_q[$];
      logic [7:0] seq [4];
      int         chars;
      int         c;
      int         k;
      int         len;
      chars = $urandom_range(1, 8);
      for (c = 0; c < chars; c++) begin
         if (c == chars - 1 && $urandom_range(99) < 25) begin
            len = make_char(seq);
            if (len > 1) begin
               len = $urandom_range(1, len - 1);
            end
            for (k = 0; k < len; k++) begin
               text_q = {text_q, seq[k]};
            end
         end else if ($urandom_range(99) < 10) begin
            text_q = {text_q, 8'($urandom_range(8'h00, 8'hFF))};
         end else begin
            len = make_char(seq);
            for (k = 0; k < len; k++) begin
               text_q = {text_q, seq[k]};
            end
         end
      end
      foreach (text_q[n]) begin
         send_byte(text_q[n], n == text_q.size() - 1);
      end
      sent += text_q.size();
   endtask

   // Directed strings: byte extremes, stray continuation and invalid leads,
   // an overlong form, a three-byte character, a code point beyond U+10FFFF
   // as a surrogate pair, an ASCII byte in a continuation slot, and strings
   // that end on a lone lead, one byte into a sequence and two bytes into one,
   // with the bytes after the lead decoded again as ASCII, as a two-byte
   // character and as further leads.
   task automatic run_directed();
      send_byte(8'h00, 1'b0);
      send_byte(8'h7F, 1'b0);
      send_byte(8'hBF, 1'b0);   // continuation byte with no lead
      send_byte(8'hF8, 1'b0);   // byte that can never lead
      send_byte(8'hFF, 1'b1);
      send_byte(8'hC0, 1'b0);   // overlong encoding of U+0000
      send_byte(8'h80, 1'b0);
      send_byte(8'hE2, 1'b0);   // euro sign
      send_byte(8'h82, 1'b0);
      send_byte(8'hAC, 1'b0);
      send_byte(8'hF7, 1'b0);   // largest four-byte form, far above U+10FFFF
      send_byte(8'hBF, 1'b0);
      send_byte(8'hBF, 1'b0);
      send_byte(8'hBF, 1'b1);
      send_byte(8'hE2, 1'b0);   // ASCII and a lead taken as continuations
      send_byte(8'h41, 1'b0);
      send_byte(8'hF0, 1'b0);
      send_byte(8'hC3, 1'b1);   // lead that meets the end of the string
      send_byte(8'hF0, 1'b0);   // three units from one final byte
      send_byte(8'h41, 1'b0);
      send_byte(8'h42, 1'b1);
      send_byte(8'hF0, 1'b0);   // held bytes form a two-byte character
      send_byte(8'hC5, 1'b0);
      send_byte(8'h80, 1'b1);
      send_byte(8'hF0, 1'b0);   // held bytes hold another lead
      send_byte(8'hE2, 1'b0);
      send_byte(8'h82, 1'b1);
      send_byte(8'hF0, 1'b0);   // string cut after one continuation
      send_byte(8'h9F, 1'b1);
   endtask

   // -------------------------------------------------------------------------
   // Test sequence. The directed strings and the first third of the random
   // bytes run with a slow sender and a stalling receiver, the second third
   // swaps the two, and the last third runs at full rate on both sides.
   // -------------------------------------------------------------------------
   initial begin
      int sent;
      units_board    = new();
      send_idle_pct  = 10;
      recv_stall_pct = 47;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      run_directed();

      sent = 0;
      while (sent < RANDOM_BYTES) begin
         if (sent >= 2 * RANDOM_BYTES / 3) begin
            send_idle_pct  = 0;
            recv_stall_pct = 0;
         end else if (sent >= RANDOM_BYTES / 3) begin
            send_idle_pct  = 47;
            recv_stall_pct = 10;
         end
         send_random_string(sent);
      end
      req_valid <= 1'b0;

      // Wait for every predicted unit, then a few more cycles so that any
      // spurious extra unit is caught before the verdict.
      while (units_board.outstanding() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d bytes in %0d strings and checked %0d code units,",
               units_board.bytes_seen, units_board.strings_seen,
               units_board.units_seen);
      $display("under slow-sender, slow-receiver and full-rate traffic; %0d mismatches.",
               units_board.mismatches);
      if (units_board.mismatches == 0 && units_board.outstanding() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
